@@ hw/rtl/clip_playback_cursor_advance_defines.svh @@
// Assertion macros shared by the clip playback cursor advance RTL.
`ifndef CLIP_PLAYBACK_CURSOR_ADVANCE_DEFINES_SVH
`define CLIP_PLAYBACK_CURSOR_ADVANCE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cpa_pkg.sv @@
// Types and constants of the clip playback cursor advance block.
`default_nettype none
package cpa_pkg;
    localparam int QBITS = 64;

    localparam logic [30:0] MAX_DURATION       = 31'h7FFF_FFFF;
    localparam logic [31:0] MAX_CROSSING_LIMIT = 32'd65535;

    localparam logic [1:0] MODE_ONCE     = 2'd0;
    localparam logic [1:0] MODE_CLAMP    = 2'd1;
    localparam logic [1:0] MODE_LOOP     = 2'd2;
    localparam logic [1:0] MODE_PINGPONG = 2'd3;

    localparam logic [1:0] ADM_ACCEPT   = 2'd0;
    localparam logic [1:0] ADM_CANCEL   = 2'd1;
    localparam logic [1:0] ADM_REFUSE   = 2'd2;
    localparam logic [1:0] ADM_RESERVED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_BUDGET    = 3'd5;

    localparam logic [1:0] DIR_HELD    = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    localparam logic [1:0] CFG_WRAP_MODE     = 2'd0;
    localparam logic [1:0] CFG_CLIP_DURATION = 2'd1;
    localparam logic [1:0] CFG_MAX_CROSSINGS = 2'd2;

    typedef struct packed {
        logic        early;
        logic [2:0]  status;
        logic [31:0] phase_o;
        logic        term_o;
        logic [30:0] smp_o;
        logic [1:0]  dir_o;
        logic [15:0] cr_o;
        logic        up;
        logic        pp;
        logic        neg;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] uw;
        logic [30:0] ur;
        logic [63:0] pw;
        logic [30:0] pr;
    } lane_t;
endpackage
`default_nettype wire

@@ hw/rtl/cpa_cell.sv @@
// One restoring division step for the advanced position and the start phase.
`default_nettype none
module cpa_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic [30:0]   dur,
    input  wire logic          v_in,
    input  wire cpa_pkg::lane_t lane_in,
    output logic               v_reg,
    output cpa_pkg::lane_t     lane_reg
);
    cpa_pkg::lane_t lane_next;
    logic [31:0] ux;
    logic [31:0] px;
    logic [31:0] usub;
    logic [31:0] psub;
    logic        uge;
    logic        pge;

    always_comb
    begin
        ux   = {lane_in.ur, lane_in.uw[63]};
        px   = {lane_in.pr, lane_in.pw[63]};
        usub = ux - {1'b0, dur};
        psub = px - {1'b0, dur};
        uge  = ux >= {1'b0, dur};
        pge  = px >= {1'b0, dur};
        lane_next    = lane_in;
        lane_next.ur = uge ? usub[30:0] : ux[30:0];
        lane_next.uw = {lane_in.uw[62:0], uge};
        lane_next.pr = pge ? psub[30:0] : px[30:0];
        lane_next.pw = {lane_in.pw[62:0], pge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/cpa_back.sv @@
// Quotient fixup, crossing count and result register of the cursor advance.
`default_nettype none
module cpa_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [30:0]    dur,
    input  wire logic [15:0]    max_crossings,
    input  wire logic           v_in,
    input  wire cpa_pkg::lane_t lane_in,
    output logic                out_valid_reg,
    output logic [2:0]          status_reg,
    output logic [31:0]         phase_reg,
    output logic                term_reg,
    output logic [30:0]         smp_reg,
    output logic [1:0]          dir_reg,
    output logic [15:0]         cr_reg
);
    logic [31:0] d32;
    logic [31:0] d2;
    logic        e;
    logic [63:0] fd;
    logic [63:0] cd;
    logic [31:0] modd;
    logic [31:0] m;
    logic [31:0] mod2d;
    logic [63:0] pd;
    logic [63:0] fd_next;
    logic [31:0] np_next;

    logic          b_v_reg;
    cpa_pkg::side_t b_side_reg;
    logic [63:0]   b_fd_reg;
    logic [63:0]   b_pd_reg;
    logic [31:0]   b_np_reg;

    logic [63:0] cr;
    logic        over;
    logic [31:0] prior;
    logic [31:0] tp;
    logic [31:0] tc;
    logic [1:0]  dir_c;

    always_comb
    begin
        d32 = {1'b0, dur};
        d2  = {dur, 1'b0};
        e   = lane_in.ur == (dur - 31'd1);
        if (lane_in.side.neg)
        begin
            fd    = ~lane_in.uw;
            cd    = e ? ~lane_in.uw : ~lane_in.uw + 64'd1;
            modd  = e ? 32'd0 : d32 - {1'b0, lane_in.ur} - 32'd1;
            m     = ((lane_in.uw[0] ^ e) ? d32 : 32'd0)
                    + (e ? 32'd0 : {1'b0, lane_in.ur} + 32'd1);
            mod2d = (m == 32'd0) ? 32'd0 : d2 - m;
        end
        else
        begin
            fd    = lane_in.uw;
            cd    = lane_in.uw + {63'd0, lane_in.ur != 31'd0};
            modd  = {1'b0, lane_in.ur};
            m     = (lane_in.uw[0] ? d32 : 32'd0) + {1'b0, lane_in.ur};
            mod2d = m;
        end
        pd      = lane_in.side.up ? lane_in.pw
                                  : lane_in.pw + {63'd0, lane_in.pr != 31'd0};
        fd_next = lane_in.side.up ? fd : cd;
        np_next = lane_in.side.pp ? mod2d : modd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg       <= v_in;
            out_valid_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg <= lane_in.side;
            b_fd_reg   <= fd_next;
            b_pd_reg   <= pd;
            b_np_reg   <= np_next;
        end
    end

    always_comb
    begin
        cr   = b_side_reg.up ? b_fd_reg - b_pd_reg : b_pd_reg - b_fd_reg;
        over = (cr > {48'd0, max_crossings})
               || (cr > {32'd0, cpa_pkg::MAX_CROSSING_LIMIT});
        if (b_side_reg.up)
        begin
            prior = (b_np_reg == 32'd0) ? d2 - 32'd1 : b_np_reg - 32'd1;
        end
        else
        begin
            prior = (b_np_reg == d2 - 32'd1) ? 32'd0 : b_np_reg + 32'd1;
        end
        tp = (prior <= d32) ? prior : d2 - prior;
        tc = (b_np_reg <= d32) ? b_np_reg : d2 - b_np_reg;
        if (b_side_reg.pp)
        begin
            dir_c = (tc >= tp) ? cpa_pkg::DIR_FORWARD : cpa_pkg::DIR_REVERSE;
        end
        else
        begin
            dir_c = b_side_reg.up ? cpa_pkg::DIR_FORWARD : cpa_pkg::DIR_REVERSE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (b_side_reg.early)
            begin
                status_reg <= b_side_reg.status;
                phase_reg  <= b_side_reg.phase_o;
                term_reg   <= b_side_reg.term_o;
                smp_reg    <= b_side_reg.smp_o;
                dir_reg    <= b_side_reg.dir_o;
                cr_reg     <= b_side_reg.cr_o;
            end
            else if (over)
            begin
                status_reg <= cpa_pkg::ST_BUDGET;
                phase_reg  <= 32'd0;
                term_reg   <= 1'b0;
                smp_reg    <= 31'd0;
                dir_reg    <= cpa_pkg::DIR_HELD;
                cr_reg     <= 16'd0;
            end
            else
            begin
                status_reg <= cpa_pkg::ST_OK;
                phase_reg  <= b_np_reg;
                term_reg   <= 1'b0;
                smp_reg    <= b_side_reg.pp ? tc[30:0] : b_np_reg[30:0];
                dir_reg    <= dir_c;
                cr_reg     <= cr[15:0];
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/clip_playback_cursor_advance.sv @@
// Top level of the clip playback cursor advance block.
// The block takes one cursor advance per cycle while the result side does not stall. Each
// accepted item passes through one input stage, a row of 64 restoring division cells that
// divide the advanced position and the start phase by the clip duration one quotient bit
// per cell, a quotient fixup stage, and the result register, which forms the crossing count
// and the sample time. A stall on the result side holds the whole row. Configuration
// takes effect on the items accepted after the write and must be written while no item
// is in flight.
`default_nettype none
`include "clip_playback_cursor_advance_defines.svh"
module clip_playback_cursor_advance (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  admission,
    input  wire logic [31:0] cursor_phase,
    input  wire logic        cursor_terminal,
    input  wire logic signed [63:0] delta_ticks,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [2:0]       status,
    output logic [31:0]      new_phase,
    output logic             new_terminal,
    output logic [30:0]      sample_time,
    output logic [1:0]       direction,
    output logic [15:0]      crossings
);
    logic [1:0]  wrap_mode_reg;
    logic [30:0] clip_duration_reg;
    logic [15:0] max_crossings_reg;

    logic        en;
    logic [30:0] dur;
    logic [32:0] upper;
    logic [64:0] sum;
    logic [63:0] unb;
    logic        ovf;
    logic        up;
    logic [31:0] cnp;
    logic        reached;
    logic        ccr;
    logic [31:0] held_smp;
    cpa_pkg::lane_t lane_next;

    logic           f_v_reg;
    cpa_pkg::lane_t f_lane_reg;

    logic           v [cpa_pkg::QBITS+1];
    cpa_pkg::lane_t lanes [cpa_pkg::QBITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg     <= cpa_pkg::MODE_ONCE;
            clip_duration_reg <= 31'd1;
            max_crossings_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpa_pkg::CFG_WRAP_MODE:     wrap_mode_reg     <= cfg_data[1:0];
                cpa_pkg::CFG_CLIP_DURATION: clip_duration_reg <= cfg_data;
                cpa_pkg::CFG_MAX_CROSSINGS: max_crossings_reg <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    assign en         = !result_valid || result_ready;
    assign item_ready = en;

    always_comb
    begin
        if (clip_duration_reg == 31'd0)
        begin
            dur = 31'd1;
        end
        else if (clip_duration_reg > cpa_pkg::MAX_DURATION)
        begin
            dur = cpa_pkg::MAX_DURATION;
        end
        else
        begin
            dur = clip_duration_reg;
        end
        case (wrap_mode_reg)
            cpa_pkg::MODE_LOOP:     upper = {2'b0, dur};
            cpa_pkg::MODE_PINGPONG: upper = {1'b0, dur, 1'b0};
            default:                upper = {2'b0, dur} + 33'd1;
        endcase
        sum = {delta_ticks[63], delta_ticks} + {33'd0, cursor_phase};
        unb = sum[63:0];
        ovf = sum[64] ^ sum[63];
        up  = !delta_ticks[63];
        if (unb[63])
        begin
            cnp = 32'd0;
        end
        else if (unb > {33'd0, dur})
        begin
            cnp = {1'b0, dur};
        end
        else
        begin
            cnp = unb[31:0];
        end
        reached  = ({32'd0, cnp} != unb) || (up ? cnp == {1'b0, dur} : cnp == 32'd0);
        ccr      = reached && (cursor_phase != cnp);
        held_smp = (cursor_phase <= {1'b0, dur}) ? cursor_phase
                                                 : {dur, 1'b0} - cursor_phase;

        lane_next         = '0;
        lane_next.uw      = unb[63] ? ~unb : unb;
        lane_next.pw      = {32'd0, cursor_phase};
        lane_next.side.up = up;
        lane_next.side.pp = wrap_mode_reg == cpa_pkg::MODE_PINGPONG;
        lane_next.side.neg = unb[63];
        lane_next.side.early = 1'b1;
        if (admission == cpa_pkg::ADM_CANCEL)
        begin
            lane_next.side.status = cpa_pkg::ST_CANCELLED;
        end
        else if (admission != cpa_pkg::ADM_ACCEPT)
        begin
            lane_next.side.status = cpa_pkg::ST_REJECTED;
        end
        else if ({16'd0, max_crossings_reg} > cpa_pkg::MAX_CROSSING_LIMIT)
        begin
            lane_next.side.status = cpa_pkg::ST_BUDGET;
        end
        else if ((cursor_terminal && wrap_mode_reg != cpa_pkg::MODE_ONCE)
                 || ({1'b0, cursor_phase} >= upper))
        begin
            lane_next.side.status = cpa_pkg::ST_MALFORMED;
        end
        else if (cursor_terminal || delta_ticks == 64'sd0)
        begin
            lane_next.side.status  = cpa_pkg::ST_OK;
            lane_next.side.phase_o = cursor_phase;
            lane_next.side.term_o  = cursor_terminal;
            lane_next.side.smp_o   = (wrap_mode_reg == cpa_pkg::MODE_PINGPONG)
                                     ? held_smp[30:0] : cursor_phase[30:0];
            lane_next.side.dir_o   = cpa_pkg::DIR_HELD;
        end
        else if (ovf)
        begin
            lane_next.side.status = cpa_pkg::ST_OVERFLOW;
        end
        else if (wrap_mode_reg == cpa_pkg::MODE_ONCE || wrap_mode_reg == cpa_pkg::MODE_CLAMP)
        begin
            if ({15'd0, ccr} > max_crossings_reg)
            begin
                lane_next.side.status = cpa_pkg::ST_BUDGET;
            end
            else
            begin
                lane_next.side.status  = cpa_pkg::ST_OK;
                lane_next.side.phase_o = cnp;
                lane_next.side.term_o  = (wrap_mode_reg == cpa_pkg::MODE_ONCE) && reached;
                lane_next.side.smp_o   = cnp[30:0];
                lane_next.side.cr_o    = {15'd0, ccr};
                if (cnp == cursor_phase)
                begin
                    lane_next.side.dir_o = cpa_pkg::DIR_HELD;
                end
                else
                begin
                    lane_next.side.dir_o = (cnp > cursor_phase) ? cpa_pkg::DIR_FORWARD
                                                                : cpa_pkg::DIR_REVERSE;
                end
            end
        end
        else
        begin
            lane_next.side.early = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_lane_reg <= lane_next;
        end
    end

    assign v[0]     = f_v_reg;
    assign lanes[0] = f_lane_reg;

    for (genvar i = 0; i < cpa_pkg::QBITS; i++)
    begin : g_cell
        cpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .dur      (dur),
            .v_in     (v[i]),
            .lane_in  (lanes[i]),
            .v_reg    (v[i+1]),
            .lane_reg (lanes[i+1])
        );
    end

    cpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .dur           (dur),
        .max_crossings (max_crossings_reg),
        .v_in          (v[cpa_pkg::QBITS]),
        .lane_in       (lanes[cpa_pkg::QBITS]),
        .out_valid_reg (result_valid),
        .status_reg    (status),
        .phase_reg     (new_phase),
        .term_reg      (new_terminal),
        .smp_reg       (sample_time),
        .dir_reg       (direction),
        .cr_reg        (crossings)
    );

    `CPA_ASSERT_IMP(a_error_zero, result_valid && status != cpa_pkg::ST_OK,
        new_phase == 32'd0 && !new_terminal && sample_time == 31'd0
        && direction == cpa_pkg::DIR_HELD && crossings == 16'd0,
        "error beat carries nonzero fields")
    `CPA_ASSERT_IMP(a_terminal_once, result_valid && new_terminal,
        status == cpa_pkg::ST_OK && wrap_mode_reg == cpa_pkg::MODE_ONCE,
        "terminal cursor outside once mode")
    `CPA_ASSERT_IMP(a_held_no_cross,
        result_valid && status == cpa_pkg::ST_OK && direction == cpa_pkg::DIR_HELD,
        crossings == 16'd0, "held cursor reports crossings")
    `CPA_ASSERT_NEXT(a_front_hold, f_v_reg && !en, f_v_reg,
        "input stage lost a beat during a stall")
endmodule
`default_nettype wire

@@ tb/clip_playback_cursor_advance_tb.sv @@
// Self-checking testbench of the clip playback cursor advance block.
`timescale 1ns / 1ps

typedef struct {
    logic [2:0]  status;
    logic [31:0] phase;
    logic        term;
    logic [30:0] smp;
    logic [1:0]  dir;
    logic [15:0] cr;
} advance_t;

class cursor_scoreboard;
    advance_t    pending_q[$];
    logic [1:0]  mode;
    logic [30:0] dur_reg;
    logic [15:0] max_cr;
    int          errors;
    int          checked;

    function new();
        mode = cpa_pkg::MODE_ONCE;
        dur_reg = 31'd1;
        max_cr = 16'd1;
        errors = 0;
        checked = 0;
    endfunction

    function longint fdiv(longint v, longint d);
        return v / d - ((v % d) < 0 ? 1 : 0);
    endfunction

    function longint cdiv(longint v, longint d);
        return v / d + ((v % d) > 0 ? 1 : 0);
    endfunction

    function longint fmod(longint v, longint m);
        longint r;
        r = v % m;
        return r < 0 ? r + m : r;
    endfunction

    function longint reflect(longint p, longint d);
        return p <= d ? p : 2 * d - p;
    endfunction

    function void note(logic [1:0] adm, logic [31:0] ph, logic term, longint dl);
        advance_t e;
        longint dur, upper, phs, unb, np, period, tp, tc;
        longint unsigned cnt;
        bit reached;
        e = '{default: '0};
        dur = (dur_reg == 0) ? 1 : longint'(dur_reg);
        phs = longint'({32'd0, ph});
        upper = (mode == cpa_pkg::MODE_LOOP) ? dur :
                (mode == cpa_pkg::MODE_PINGPONG) ? 2 * dur : dur + 1;
        if (adm == cpa_pkg::ADM_CANCEL)
            e.status = cpa_pkg::ST_CANCELLED;
        else if (adm != cpa_pkg::ADM_ACCEPT)
            e.status = cpa_pkg::ST_REJECTED;
        else if ((term && mode != cpa_pkg::MODE_ONCE) || phs >= upper)
            e.status = cpa_pkg::ST_MALFORMED;
        else if (term || dl == 0)
        begin
            e.status = cpa_pkg::ST_OK;
            e.phase = ph;
            e.term = term;
            e.smp = 31'((mode == cpa_pkg::MODE_PINGPONG) ? reflect(phs, dur) : phs);
            e.dir = cpa_pkg::DIR_HELD;
        end
        else if (dl > 0 && phs > 64'sh7FFF_FFFF_FFFF_FFFF - dl)
            e.status = cpa_pkg::ST_OVERFLOW;
        else
        begin
            unb = phs + dl;
            if (mode == cpa_pkg::MODE_ONCE || mode == cpa_pkg::MODE_CLAMP)
            begin
                np = unb < 0 ? 0 : (unb > dur ? dur : unb);
                reached = (np != unb) || (dl > 0 ? np == dur : np == 0);
                cnt = (reached && phs != np) ? 64'd1 : 64'd0;
                if (cnt > max_cr)
                    e.status = cpa_pkg::ST_BUDGET;
                else
                begin
                    e.status = cpa_pkg::ST_OK;
                    e.phase = 32'(np);
                    e.term = (mode == cpa_pkg::MODE_ONCE) && reached;
                    e.smp = 31'(np);
                    e.dir = (np == phs) ? cpa_pkg::DIR_HELD :
                            (np > phs ? cpa_pkg::DIR_FORWARD : cpa_pkg::DIR_REVERSE);
                    e.cr = 16'(cnt);
                end
            end
            else
            begin
                if (unb > phs)
                    cnt = longint'(fdiv(unb, dur)) - longint'(fdiv(phs, dur));
                else
                    cnt = longint'(cdiv(phs, dur)) - longint'(cdiv(unb, dur));
                if (cnt > max_cr)
                    e.status = cpa_pkg::ST_BUDGET;
                else if (mode == cpa_pkg::MODE_LOOP)
                begin
                    np = fmod(unb, dur);
                    e.status = cpa_pkg::ST_OK;
                    e.phase = 32'(np);
                    e.smp = 31'(np);
                    e.dir = dl > 0 ? cpa_pkg::DIR_FORWARD : cpa_pkg::DIR_REVERSE;
                    e.cr = 16'(cnt);
                end
                else
                begin
                    period = 2 * dur;
                    np = fmod(unb, period);
                    tp = reflect(fmod(np - (dl > 0 ? 1 : -1), period), dur);
                    tc = reflect(np, dur);
                    e.status = cpa_pkg::ST_OK;
                    e.phase = 32'(np);
                    e.smp = 31'(tc);
                    e.dir = tc >= tp ? cpa_pkg::DIR_FORWARD : cpa_pkg::DIR_REVERSE;
                    e.cr = 16'(cnt);
                end
            end
        end
        pending_q = {pending_q, e};
    endfunction

    function void check(advance_t got);
        advance_t e;
        checked++;
        if (pending_q.size() == 0)
        begin
            $error("result beat with no advance outstanding");
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (got.status !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
        end
        if (got.phase !== e.phase)
        begin
            $error("new_phase: expected %0d, got %0d", e.phase, got.phase);
            errors++;
        end
        if (got.term !== e.term)
        begin
            $error("new_terminal: expected %0d, got %0d", e.term, got.term);
            errors++;
        end
        if (got.smp !== e.smp)
        begin
            $error("sample_time: expected %0d, got %0d", e.smp, got.smp);
            errors++;
        end
        if (got.dir !== e.dir)
        begin
            $error("direction: expected %0d, got %0d", e.dir, got.dir);
            errors++;
        end
        if (got.cr !== e.cr)
        begin
            $error("crossings: expected %0d, got %0d", e.cr, got.cr);
            errors++;
        end
    endfunction
endclass

module clip_playback_cursor_advance_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = cpa_pkg::CFG_WRAP_MODE;
    logic [30:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  admission = cpa_pkg::ADM_ACCEPT;
    logic [31:0] cursor_phase = '0;
    logic        cursor_terminal = 1'b0;
    logic signed [63:0] delta_ticks = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] new_phase;
    logic        new_terminal;
    logic [30:0] sample_time;
    logic [1:0]  direction;
    logic [15:0] crossings;

    cursor_scoreboard sb = new();
    bit quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int sent = 0;
    int settings_run = 0;

    clip_playback_cursor_advance uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        advance_t got;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got.status = status;
                got.phase = new_phase;
                got.term = new_terminal;
                got.smp = sample_time;
                got.dir = direction;
                got.cr = crossings;
                sb.check(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 20000)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function longint unsigned rnd64(longint unsigned n);
        longint unsigned r;
        r = {$urandom, $urandom};
        return (n == 64'hFFFF_FFFF_FFFF_FFFF) ? r : r % (n + 1);
    endfunction

    task write_reg(logic [1:0] idx, logic [30:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task drain();
        item_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task configure(logic [1:0] m, logic [30:0] d, logic [15:0] c);
        drain();
        write_reg(cpa_pkg::CFG_WRAP_MODE, m);
        write_reg(cpa_pkg::CFG_CLIP_DURATION, d);
        write_reg(cpa_pkg::CFG_MAX_CROSSINGS, c);
        cfg_we <= 1'b0;
        sb.mode = m;
        sb.dur_reg = d;
        sb.max_cr = c;
        settings_run++;
    endtask

    task send_item(logic [1:0] adm, logic [31:0] ph, logic term, longint dl);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_valid <= 1'b1;
        admission <= adm;
        cursor_phase <= ph;
        cursor_terminal <= term;
        delta_ticks <= dl;
        do @(posedge clk); while (!item_ready);
        sb.note(adm, ph, term, dl);
        sent++;
    endtask

    task send_random();
        longint dur, top, k, dl;
        logic [1:0] adm;
        logic [31:0] ph;
        dur = (sb.dur_reg == 0) ? 1 : longint'(sb.dur_reg);
        top = (sb.mode == cpa_pkg::MODE_LOOP) ? dur - 1 :
              (sb.mode == cpa_pkg::MODE_PINGPONG) ? 2 * dur - 1 : dur;
        adm = ($urandom_range(0, 9) == 0) ? 2'($urandom) : cpa_pkg::ADM_ACCEPT;
        case ($urandom_range(0, 7))
            0: ph = $urandom;
            1: ph = 32'((longint'($urandom_range(0, 4)) * dur + $urandom_range(0, 2)) - 1);
            default: ph = 32'(rnd64(top));
        endcase
        case ($urandom_range(0, 9))
            0: dl = {$urandom, $urandom};
            1: dl = 0;
            2: dl = $urandom_range(0, 1) ? 64'sh7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 2)
                                          : 64'sh8000_0000_0000_0000 + $urandom_range(0, 2);
            3, 4: dl = longint'(rnd64(3 * dur)) * ($urandom_range(0, 1) ? 1 : -1);
            default:
            begin
                k = $urandom_range(0, sb.max_cr + 1);
                dl = k * dur + longint'(rnd64(2 * dur)) - dur;
                if ($urandom_range(0, 1))
                    dl = -dl;
            end
        endcase
        send_item(adm, ph, $urandom_range(0, 9) == 0, dl);
    endtask

    initial
    begin
        logic [30:0] durs [5];
        logic [15:0] budgets [4];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(cpa_pkg::MODE_ONCE, 31'd100, 16'd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd0, 1'b0, 64'sd0);
        send_item(cpa_pkg::ADM_CANCEL, 32'd5, 1'b0, 64'sd1);
        send_item(cpa_pkg::ADM_REFUSE, 32'd5, 1'b0, 64'sd1);
        send_item(cpa_pkg::ADM_RESERVED, 32'hFFFF_FFFF, 1'b1, -64'sd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd101, 1'b0, 64'sd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'hFFFF_FFFF, 1'b0, 64'sd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd50, 1'b1, 64'sd7);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd100, 1'b1, 64'sd0);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd100, 1'b0, 64'sh7FFF_FFFF_FFFF_FFFF);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd0, 1'b0, 64'sh7FFF_FFFF_FFFF_FFFF);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd100, 1'b0, 64'sh8000_0000_0000_0000);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd40, 1'b0, 64'sd60);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd40, 1'b0, -64'sd40);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd40, 1'b0, 64'sd20);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd0, 1'b0, -64'sd5);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd100, 1'b0, 64'sd5);
        configure(cpa_pkg::MODE_ONCE, 31'd100, 16'd0);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd40, 1'b0, 64'sd500);
        configure(cpa_pkg::MODE_CLAMP, 31'd100, 16'd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd40, 1'b1, 64'sd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd40, 1'b0, 64'sd500);
        configure(cpa_pkg::MODE_LOOP, 31'd0, 16'd65535);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd0, 1'b0, -64'sd3);
        send_item(cpa_pkg::ADM_ACCEPT, 32'd1, 1'b0, 64'sd1);
        configure(cpa_pkg::MODE_PINGPONG, 31'h7FFF_FFFF, 16'd2);
        send_item(cpa_pkg::ADM_ACCEPT, 32'hFFFF_FFFD, 1'b0, 64'sd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'hFFFF_FFFE, 1'b0, 64'sd1);
        send_item(cpa_pkg::ADM_ACCEPT, 32'h8000_0000, 1'b0, 64'sd0);

        durs = '{31'd0, 31'd1, 31'd0, 31'h7FFF_FFFF, 31'd0};
        budgets = '{16'd0, 16'd1, 16'd65535, 16'd0};
        for (int p = 0; p < 16; p++)
        begin
            logic [30:0] d;
            logic [15:0] c;
            d = durs[(p / 4 + p) % 5];
            if (d == 0 && (p % 3) != 0)
                d = 31'($urandom_range(2, 60));
            else if (d == 0 && p > 8)
                d = 31'($urandom_range(1000, 31'h7FFF_FFFF));
            c = budgets[(p + p / 4) % 4];
            if (c == 0 && (p % 2) == 1)
                c = 16'($urandom_range(2, 40));
            configure(2'(p % 4), d, c);
            quiet = (p >= 14);
            repeat (62) send_random();
        end

        drain();
        $display("Covered %0d cursor advances over %0d register settings in all four wrap modes,",
                 sent, settings_run);
        $display("with %0d result beats checked under random valid and ready gaps.", sb.checked);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
